### rtl/bee_pkg.sv
package bee_pkg;

    // Command codes carried in the kind field.
    localparam logic [2:0] KIND_TICK        = 3'd0;
    localparam logic [2:0] KIND_SET         = 3'd1;
    localparam logic [2:0] KIND_FADE        = 3'd2;
    localparam logic [2:0] KIND_START_PULSE = 3'd3;
    localparam logic [2:0] KIND_START_FLASH = 3'd4;
    localparam logic [2:0] KIND_MODE        = 3'd5;
    localparam logic [2:0] KIND_ENTER_TEMP  = 3'd6;
    localparam logic [2:0] KIND_LEAVE_TEMP  = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] REG_CONSTANT_LEVEL      = 3'd0;
    localparam logic [2:0] REG_PULSE_LOW           = 3'd1;
    localparam logic [2:0] REG_PULSE_HIGH          = 3'd2;
    localparam logic [2:0] REG_PULSE_STEP_TICKS    = 3'd3;
    localparam logic [2:0] REG_FLASH_LOW           = 3'd4;
    localparam logic [2:0] REG_FLASH_HIGH          = 3'd5;
    localparam logic [2:0] REG_FLASH_ON_STEP_TICKS = 3'd6;
    localparam logic [2:0] REG_FLASH_OFF_TICKS     = 3'd7;

    // Mode-flag bit positions used by mode dispatch and the saved mode.
    localparam int FLAG_BIT_CONST = 0;
    localparam int FLAG_BIT_FADE  = 1;
    localparam int FLAG_BIT_PULSE = 2;
    localparam int FLAG_BIT_FLASH = 3;

    localparam logic [3:0] FLAG_NONE  = 4'b0000;
    localparam logic [3:0] FLAG_CONST = 4'b0001;
    localparam logic [3:0] FLAG_FADE  = 4'b0010;
    localparam logic [3:0] FLAG_PULSE = 4'b0100;
    localparam logic [3:0] FLAG_FLASH = 4'b1000;

    localparam logic [5:0]  MAX_LEVEL           = 6'd63;
    localparam logic [15:0] DISPATCH_FADE_SPEED = 16'd50;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_CONST = 3'd1,
        MODE_FADE  = 3'd2,
        MODE_PULSE = 3'd3,
        MODE_FLASH = 3'd4
    } mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  level_value;
        logic [15:0] fade_speed;
        logic [3:0]  mode_flags;
    } bee_in_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [5:0] level;
        logic [2:0] active_mode;
        logic       temp_active;
    } bee_out_t;

    typedef struct packed {
        logic [5:0]  constant_level;
        logic [5:0]  pulse_low;
        logic [5:0]  pulse_high;
        logic [15:0] pulse_step_ticks;
        logic [5:0]  flash_low;
        logic [5:0]  flash_high;
        logic [15:0] flash_on_step_ticks;
        logic [15:0] flash_off_ticks;
    } bee_cfg_t;

    localparam logic [7:0] GAMMA_TAB [64] = '{
        8'd0,   8'd1,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,
        8'd7,   8'd8,   8'd9,   8'd11,  8'd12,  8'd13,  8'd14,  8'd16,
        8'd18,  8'd20,  8'd22,  8'd24,  8'd26,  8'd28,  8'd30,  8'd33,
        8'd35,  8'd38,  8'd41,  8'd44,  8'd47,  8'd50,  8'd53,  8'd57,
        8'd61,  8'd65,  8'd69,  8'd72,  8'd76,  8'd81,  8'd85,  8'd90,
        8'd95,  8'd99,  8'd105, 8'd110, 8'd115, 8'd120, 8'd126, 8'd132,
        8'd138, 8'd144, 8'd150, 8'd156, 8'd162, 8'd169, 8'd176, 8'd183,
        8'd190, 8'd198, 8'd208, 8'd219, 8'd227, 8'd235, 8'd245, 8'd255
    };

    function automatic logic [7:0] gamma_lookup(input logic [5:0] idx);
        return GAMMA_TAB[idx];
    endfunction

    function automatic logic [5:0] inc_level(input logic [5:0] v);
        return (v == MAX_LEVEL) ? MAX_LEVEL : v + 6'd1;
    endfunction

    function automatic logic [5:0] dec_level(input logic [5:0] v);
        return (v == 6'd0) ? 6'd0 : v - 6'd1;
    endfunction

    function automatic logic [3:0] mode_to_flag(input mode_t m);
        logic [3:0] f;
        case (m)
            MODE_CONST: f = FLAG_CONST;
            MODE_FADE:  f = FLAG_FADE;
            MODE_PULSE: f = FLAG_PULSE;
            MODE_FLASH: f = FLAG_FLASH;
            default:    f = FLAG_NONE;
        endcase
        return f;
    endfunction

endpackage

### rtl/bee_cfg_regs.sv
module bee_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output bee_pkg::bee_cfg_t cfg
);

    bee_pkg::bee_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bee_pkg::REG_CONSTANT_LEVEL:      cfg_reg.constant_level      <= cfg_data[5:0];
                bee_pkg::REG_PULSE_LOW:           cfg_reg.pulse_low           <= cfg_data[5:0];
                bee_pkg::REG_PULSE_HIGH:          cfg_reg.pulse_high          <= cfg_data[5:0];
                bee_pkg::REG_PULSE_STEP_TICKS:    cfg_reg.pulse_step_ticks    <= cfg_data;
                bee_pkg::REG_FLASH_LOW:           cfg_reg.flash_low           <= cfg_data[5:0];
                bee_pkg::REG_FLASH_HIGH:          cfg_reg.flash_high          <= cfg_data[5:0];
                bee_pkg::REG_FLASH_ON_STEP_TICKS: cfg_reg.flash_on_step_ticks <= cfg_data;
                bee_pkg::REG_FLASH_OFF_TICKS:     cfg_reg.flash_off_ticks     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/bee_core.sv
module bee_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  bee_pkg::bee_in_t  item,
    input  bee_pkg::bee_cfg_t cfg,
    output bee_pkg::bee_out_t result
);

    bee_pkg::mode_t mode_reg, mode_next;
    logic           ramp_reg, ramp_next;
    logic [5:0]     level_reg, level_next;
    logic [5:0]     target_reg, target_next;
    logic [15:0]    tick_reg, tick_next;
    logic [15:0]    interval_reg, interval_next;
    logic [7:0]     duty_reg, duty_next;
    logic [3:0]     saved_reg, saved_next;
    logic           temp_reg, temp_next;

    logic [15:0] thresh;
    logic        due;
    logic [5:0]  lvl_up;
    logic [5:0]  lvl_dn;
    logic [5:0]  fade_cmd_target;
    logic        dispatch_en;
    logic [3:0]  dispatch_flags;

    // The step interval that applies depends on the effect and, for flash, on its phase.
    always_comb begin
        case (mode_reg)
            bee_pkg::MODE_PULSE: thresh = cfg.pulse_step_ticks;
            bee_pkg::MODE_FLASH: thresh = ramp_reg ? cfg.flash_on_step_ticks
                                                   : cfg.flash_off_ticks;
            default:             thresh = interval_reg;
        endcase
    end

    assign due    = (tick_reg >= thresh);
    assign lvl_up = bee_pkg::inc_level(level_reg);
    assign lvl_dn = bee_pkg::dec_level(level_reg);
    assign fade_cmd_target = (|item.level_value[7:6]) ? bee_pkg::MAX_LEVEL
                                                      : item.level_value[5:0];

    always_comb begin
        mode_next      = mode_reg;
        ramp_next      = ramp_reg;
        level_next     = level_reg;
        target_next    = target_reg;
        tick_next      = tick_reg;
        interval_next  = interval_reg;
        duty_next      = duty_reg;
        saved_next     = saved_reg;
        temp_next      = temp_reg;
        dispatch_en    = 1'b0;
        dispatch_flags = bee_pkg::FLAG_NONE;

        case (item.kind)
            bee_pkg::KIND_TICK: begin
                if (mode_reg == bee_pkg::MODE_FADE || mode_reg == bee_pkg::MODE_PULSE
                        || mode_reg == bee_pkg::MODE_FLASH) begin
                    tick_next = due ? 16'd0 : tick_reg + 16'd1;
                end
                case (mode_reg)
                    bee_pkg::MODE_FADE: begin
                        if (due) begin
                            if (ramp_reg) begin
                                level_next = lvl_up;
                                if (lvl_up >= target_reg) begin
                                    level_next = target_reg;
                                    mode_next  = bee_pkg::MODE_CONST;
                                end
                            end else begin
                                level_next = lvl_dn;
                                if (lvl_dn <= target_reg) begin
                                    level_next = target_reg;
                                    mode_next  = bee_pkg::MODE_CONST;
                                end
                            end
                        end
                        duty_next = bee_pkg::gamma_lookup(level_next);
                    end
                    bee_pkg::MODE_PULSE: begin
                        if (due) begin
                            if (ramp_reg) begin
                                level_next = lvl_up;
                                if (lvl_up >= cfg.pulse_high) begin
                                    level_next = cfg.pulse_high;
                                    ramp_next  = 1'b0;
                                end
                            end else begin
                                level_next = lvl_dn;
                                if (lvl_dn <= cfg.pulse_low) begin
                                    level_next = cfg.pulse_low;
                                    ramp_next  = 1'b1;
                                end
                            end
                        end
                        duty_next = bee_pkg::gamma_lookup(level_next);
                    end
                    bee_pkg::MODE_FLASH: begin
                        if (due) begin
                            if (ramp_reg) begin
                                // The ramp-down ends at the low bound without clamping to it.
                                level_next = lvl_dn;
                                if (lvl_dn <= cfg.flash_low) begin
                                    ramp_next = 1'b0;
                                end
                            end else begin
                                level_next = cfg.flash_high;
                                ramp_next  = 1'b1;
                            end
                        end
                        duty_next = bee_pkg::gamma_lookup(level_next);
                    end
                    default: begin
                    end
                endcase
            end
            bee_pkg::KIND_SET: begin
                mode_next = bee_pkg::MODE_CONST;
                duty_next = bee_pkg::gamma_lookup(item.level_value[5:0]);
            end
            bee_pkg::KIND_FADE: begin
                tick_next     = 16'd0;
                target_next   = fade_cmd_target;
                interval_next = item.fade_speed;
                mode_next     = bee_pkg::MODE_FADE;
                ramp_next     = (level_reg < fade_cmd_target);
            end
            bee_pkg::KIND_START_PULSE: begin
                tick_next = 16'd0;
                mode_next = bee_pkg::MODE_PULSE;
                ramp_next = 1'b1;
            end
            bee_pkg::KIND_START_FLASH: begin
                tick_next = 16'd0;
                mode_next = bee_pkg::MODE_FLASH;
                ramp_next = 1'b1;
            end
            bee_pkg::KIND_MODE: begin
                // While full brightness is in force, a mode request only replaces the saved mode.
                if (temp_reg) begin
                    saved_next = item.mode_flags;
                end else begin
                    dispatch_en    = 1'b1;
                    dispatch_flags = item.mode_flags;
                end
            end
            bee_pkg::KIND_ENTER_TEMP: begin
                saved_next = bee_pkg::mode_to_flag(mode_reg);
                temp_next  = 1'b1;
                mode_next  = bee_pkg::MODE_CONST;
                duty_next  = bee_pkg::gamma_lookup(bee_pkg::MAX_LEVEL);
            end
            default: begin
                temp_next      = 1'b0;
                dispatch_en    = 1'b1;
                dispatch_flags = saved_reg;
            end
        endcase

        if (dispatch_en) begin
            if (dispatch_flags[bee_pkg::FLAG_BIT_CONST]) begin
                mode_next = bee_pkg::MODE_CONST;
                duty_next = bee_pkg::gamma_lookup(cfg.constant_level);
            end else if (dispatch_flags[bee_pkg::FLAG_BIT_FADE]) begin
                tick_next     = 16'd0;
                target_next   = cfg.constant_level;
                interval_next = bee_pkg::DISPATCH_FADE_SPEED;
                mode_next     = bee_pkg::MODE_FADE;
                ramp_next     = (level_reg < cfg.constant_level);
            end else if (dispatch_flags[bee_pkg::FLAG_BIT_PULSE]) begin
                tick_next = 16'd0;
                mode_next = bee_pkg::MODE_PULSE;
                ramp_next = 1'b1;
            end else if (dispatch_flags[bee_pkg::FLAG_BIT_FLASH]) begin
                tick_next = 16'd0;
                mode_next = bee_pkg::MODE_FLASH;
                ramp_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= bee_pkg::MODE_CONST;
            ramp_reg     <= 1'b0;
            level_reg    <= 6'd0;
            target_reg   <= 6'd0;
            tick_reg     <= 16'd0;
            interval_reg <= 16'd0;
            duty_reg     <= bee_pkg::gamma_lookup(6'd0);
            saved_reg    <= bee_pkg::FLAG_CONST;
            temp_reg     <= 1'b0;
        end else if (fire) begin
            mode_reg     <= mode_next;
            ramp_reg     <= ramp_next;
            level_reg    <= level_next;
            target_reg   <= target_next;
            tick_reg     <= tick_next;
            interval_reg <= interval_next;
            duty_reg     <= duty_next;
            saved_reg    <= saved_next;
            temp_reg     <= temp_next;
        end
    end

    assign result.duty        = duty_next;
    assign result.level       = level_next;
    assign result.active_mode = mode_next;
    assign result.temp_active = temp_next;

endmodule

### rtl/backlight_effect_engine_top.sv
// Backlight effect engine: turns a stream of commands into a gamma-corrected PWM duty.
// The s_ channel takes one command per request (tick, set, fade, start pulse, start
// flash, mode dispatch, enter or leave full brightness). The m_ channel returns exactly
// one result per command: duty, level, active mode and the full-brightness flag, all
// as they stand after that command. The cfg_ channel writes the eight effect registers
// by index; it is always ready and should be used only while no command is in flight.
// A command accepted into the input register passes through the update logic into the
// result register, which raises m_valid, once that register is free or draining. The
// block takes one command per cycle while m_ready stays high; each command performs its
// state update on the effect registers as it moves into the result register.
// When the receiver stalls, the result register holds its request and the input
// register keeps the next command, so up to two commands sit in the block; s_ready
// falls only when both are full and m_ready is low.
// Synchronous active-low reset clears the configuration to zero, selects constant
// mode at level zero with duty zero, and empties both registers.
module backlight_effect_engine_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bee_pkg::bee_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bee_pkg::bee_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    bee_pkg::bee_cfg_t cfg;
    bee_pkg::bee_out_t result;
    bee_pkg::bee_in_t  in_data_reg;
    bee_pkg::bee_out_t out_data_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              fire;

    // A command leaves the input register when the result register is free or draining.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    bee_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bee_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

endmodule
